// File: hdl/lfpd_pkg.sv
// ============================================================================
// lfpd_pkg: shared types and constants of the line-follow PD steering block
// Field widths, sensor geometry, register indexes and beat structs.
// ============================================================================
package lfpd_pkg;

    // Sensor geometry
    localparam int SENSOR_COUNT = 5;
    localparam int SAMPLE_MAX   = 255;
    localparam int SAMPLE_W     = 8;
    localparam int WEIGHT_SCALE = SAMPLE_MAX + 1;
    localparam int WEIGHT_SHIFT = $clog2(WEIGHT_SCALE);

    // Field widths
    localparam int TICK_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int POS_W      = 11;
    localparam int GAIN_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Position constants
    localparam logic [POS_W-1:0] POS_CENTRE     = POS_W'((SENSOR_COUNT / 2) * WEIGHT_SCALE);
    localparam logic [POS_W-1:0] POS_RIGHT_EDGE = POS_W'((SENSOR_COUNT - 1) * WEIGHT_SCALE);

    // Sums over the inner sensors: weights 1, 2 and 3
    localparam int WSUM_W = 12;
    localparam int NSUM_W = 10;

    // Controller datapath
    localparam int P_SHIFT    = 5;                    // P term divides by 32
    localparam int MAG_W      = POS_W;                // |error| and |error change|
    localparam int PROD_W     = GAIN_W + MAG_W;
    localparam int MUL_CNT_W  = $clog2(GAIN_W + 1);
    localparam int PROP_W     = PROD_W - P_SHIFT;
    localparam int DIV_W      = PROD_W + 1;           // dividend / quotient shift register
    localparam int DVS_W      = TICK_W;               // divisor and partial remainder
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int POS_Q_W    = 10;                   // position quotient stays below 1024
    localparam int DIFF_W     = 16;
    localparam int SUM_W      = DIV_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_D_ENABLE    = 3'd4;

    // Register reset values
    localparam logic [SPEED_W-1:0]  RST_MAX_SPEED = 8'd100;
    localparam logic [GAIN_W-1:0]   RST_GAIN_P    = 12'd32;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D    = 12'd0;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 8'd128;
    localparam logic                RST_D_ENABLE  = 1'b1;

    // Input beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_left;
        logic [SAMPLE_W-1:0] sample_inner_1;
        logic [SAMPLE_W-1:0] sample_inner_2;
        logic [SAMPLE_W-1:0] sample_inner_3;
        logic [SAMPLE_W-1:0] sample_right;
        logic [TICK_W-1:0]   tick_now;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic [POS_W-1:0]   line_position;
    } t_out_beat;

    // Sensor classification result
    typedef struct packed {
        logic              use_div;
        logic [POS_W-1:0]  direct_pos;
        logic [WSUM_W-1:0] wsum;
        logic [NSUM_W-1:0] nsum;
    } t_pos_info;

    // Divider launch
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
        logic [DVS_W-1:0]     rem_init;
        logic [DIV_W-1:0]     quo_init;
        logic [DVS_W-1:0]     divisor;
    } t_div_cmd;

    // Multiplier launch, two lanes
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] gain_p;
        logic [MAG_W-1:0]  mag_p;
        logic [GAIN_W-1:0] gain_d;
        logic [MAG_W-1:0]  mag_d;
    } t_mul_cmd;

endpackage

// File: hdl/line_follow_pd_steering.sv
// ============================================================================
// line_follow_pd_steering: line position estimate and PD steering
// Sequencer around a serial divider and a two-lane serial multiplier.
// ============================================================================
// Usage:
//   Input beat (i_valid / o_stall): five sensor samples and the tick count.
//   Output beat (o_valid / i_stall): left and right motor speeds and the
//   estimated line position. One output beat per input beat, in order.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
//   user must write them only while the block is idle, which the block does
//   not enforce itself; unknown indexes are ignored.
//   Timing: one item at a time. With an inner sensor over the line the
//   bit-serial divider first forms the position (10 steps); the D term is
//   formed by the same divider (24 steps) after the 12-step serial
//   multiplier, and is skipped with the derivative disabled.
//   A finished result sits in the output register; the next item is taken
//   while it waits, and the block holds its last step until it is taken.
//   Reset (synchronous, active low) restores register defaults, centres the
//   held position and clears the previous error and tick.
// ============================================================================
module line_follow_pd_steering (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  lfpd_pkg::t_in_beat                 i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output lfpd_pkg::t_out_beat                o_data,
    input  logic                               i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int POS_W  = lfpd_pkg::POS_W;
    localparam int SUM_W  = lfpd_pkg::SUM_W;
    localparam int DIFF_W = lfpd_pkg::DIFF_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_ERR   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_SAT   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    // state and registers
    logic [2:0]                              r_state;
    logic [2:0]                              n_state;
    logic [lfpd_pkg::SPEED_W-1:0]            r_max_speed;
    logic [lfpd_pkg::GAIN_W-1:0]             r_gain_p;
    logic [lfpd_pkg::GAIN_W-1:0]             r_gain_d;
    logic [lfpd_pkg::SAMPLE_W-1:0]           r_threshold;
    logic                                    r_d_enable;
    lfpd_pkg::t_in_beat                      r_in;
    logic [POS_W-1:0]                        r_held;
    logic [POS_W-1:0]                        r_pos;
    logic signed [POS_W-1:0]                 r_prev_err;
    logic [lfpd_pkg::TICK_W-1:0]             r_prev_tick;
    logic [lfpd_pkg::TICK_W-1:0]             r_ticks;
    logic                                    r_err_neg;
    logic                                    r_derr_neg;
    logic [lfpd_pkg::PROP_W-1:0]             r_prop_mag;
    logic signed [DIFF_W-1:0]                r_diff;
    lfpd_pkg::t_out_beat                     r_out;
    logic                                    r_out_valid;

    // unit hookup
    lfpd_pkg::t_pos_info                     pos_info;
    lfpd_pkg::t_div_cmd                      div_cmd;
    lfpd_pkg::t_mul_cmd                      mul_cmd;
    logic                                    div_done;
    logic [lfpd_pkg::DIV_W-1:0]              div_quo;
    logic                                    mul_done;
    logic [lfpd_pkg::PROD_W-1:0]             prod_p;
    logic [lfpd_pkg::PROD_W-1:0]             prod_d;

    // datapath nets
    logic                                    accept;
    logic                                    out_load;
    logic [lfpd_pkg::DIV_W-1:0]              pos_dividend;
    logic signed [POS_W:0]                   err_ext;
    logic signed [POS_W:0]                   err_negv;
    logic signed [POS_W-1:0]                 err;
    logic signed [POS_W:0]                   derr;
    logic signed [POS_W:0]                   derr_negv;
    logic [lfpd_pkg::TICK_W-1:0]             tick_delta;
    logic signed [SUM_W-1:0]                 prop_s;
    logic signed [SUM_W-1:0]                 deriv_s;
    logic signed [SUM_W-1:0]                 diff_full;
    logic signed [DIFF_W:0]                  d_ext;
    logic signed [DIFF_W:0]                  max_ext;
    logic signed [DIFF_W:0]                  left_sum;
    lfpd_pkg::t_out_beat                     n_out;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    lfpd_position u_position (
        .i_beat      (r_in),
        .i_threshold (r_threshold),
        .i_held      (r_held),
        .o_info      (pos_info)
    );

    lfpd_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mul_cmd),
        .o_done   (mul_done),
        .o_prod_p (prod_p),
        .o_prod_d (prod_d)
    );

    lfpd_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // error, error change and elapsed ticks
    always_comb begin
        err_ext    = $signed({1'b0, r_pos}) - $signed({1'b0, lfpd_pkg::POS_CENTRE});
        err        = err_ext[POS_W-1:0];
        err_negv   = -err_ext;
        derr       = $signed({err[POS_W-1], err}) - $signed({r_prev_err[POS_W-1], r_prev_err});
        derr_negv  = -derr;
        tick_delta = r_in.tick_now - r_prev_tick;
    end

    // multiplier launch from the error stage
    always_comb begin
        mul_cmd.start  = (r_state == S_ERR);
        mul_cmd.gain_p = r_gain_p;
        mul_cmd.gain_d = r_gain_d;
        mul_cmd.mag_p  = err_ext[POS_W] ? err_negv[lfpd_pkg::MAG_W-1:0]
                                        : err_ext[lfpd_pkg::MAG_W-1:0];
        mul_cmd.mag_d  = derr[POS_W] ? derr_negv[lfpd_pkg::MAG_W-1:0]
                                     : derr[lfpd_pkg::MAG_W-1:0];
    end

    // divider launch: position average, then the D term
    always_comb begin
        pos_dividend = lfpd_pkg::DIV_W'({pos_info.wsum, {lfpd_pkg::WEIGHT_SHIFT{1'b0}}});
        div_cmd = '0;
        if ((r_state == S_CLASS) && pos_info.use_div) begin
            div_cmd.start    = 1'b1;
            div_cmd.count    = lfpd_pkg::DIV_CNT_W'(lfpd_pkg::POS_Q_W);
            div_cmd.rem_init = lfpd_pkg::DVS_W'(pos_dividend >> lfpd_pkg::POS_Q_W);
            div_cmd.quo_init = pos_dividend << (lfpd_pkg::DIV_W - lfpd_pkg::POS_Q_W);
            div_cmd.divisor  = lfpd_pkg::DVS_W'(pos_info.nsum);
        end else if ((r_state == S_MUL) && mul_done && r_d_enable) begin
            div_cmd.start    = 1'b1;
            div_cmd.count    = lfpd_pkg::DIV_CNT_W'(lfpd_pkg::DIV_W);
            div_cmd.rem_init = '0;
            div_cmd.quo_init = lfpd_pkg::DIV_W'(prod_d);
            div_cmd.divisor  = r_ticks;
        end
    end

    // P minus D, both truncated toward zero, then 16-bit saturation
    always_comb begin
        prop_s    = $signed(SUM_W'(r_prop_mag));
        if (r_err_neg) begin
            prop_s = -prop_s;
        end
        deriv_s   = r_d_enable ? $signed(SUM_W'(div_quo)) : '0;
        if (r_derr_neg) begin
            deriv_s = -deriv_s;
        end
        diff_full = prop_s - deriv_s;
    end

    // speed clamp against the maximum
    always_comb begin
        d_ext    = {r_diff[DIFF_W-1], r_diff};
        max_ext  = $signed({{(DIFF_W + 1 - lfpd_pkg::SPEED_W){1'b0}}, r_max_speed});
        left_sum = max_ext + d_ext;
        n_out.line_position = r_pos;
        n_out.left_speed    = r_max_speed;
        n_out.right_speed   = r_max_speed;
        if (d_ext >= max_ext) begin
            n_out.right_speed = '0;
        end else if (d_ext <= -max_ext) begin
            n_out.left_speed = '0;
        end else if (d_ext >= 0) begin
            n_out.right_speed = r_max_speed - r_diff[lfpd_pkg::SPEED_W-1:0];
        end else begin
            n_out.left_speed = left_sum[lfpd_pkg::SPEED_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CLASS;
            end
            S_CLASS: begin
                n_state = pos_info.use_div ? S_POS : S_ERR;
            end
            S_POS: begin
                if (div_done) n_state = S_ERR;
            end
            S_ERR: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_done) n_state = r_d_enable ? S_DIV : S_SAT;
            end
            S_DIV: begin
                if (div_done) n_state = S_SAT;
            end
            S_SAT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_speed <= lfpd_pkg::RST_MAX_SPEED;
            r_gain_p    <= lfpd_pkg::RST_GAIN_P;
            r_gain_d    <= lfpd_pkg::RST_GAIN_D;
            r_threshold <= lfpd_pkg::RST_THRESHOLD;
            r_d_enable  <= lfpd_pkg::RST_D_ENABLE;
            r_held      <= lfpd_pkg::POS_CENTRE;
            r_prev_err  <= '0;
            r_prev_tick <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lfpd_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_wdata[lfpd_pkg::SPEED_W-1:0];
                    lfpd_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg_wdata[lfpd_pkg::GAIN_W-1:0];
                    lfpd_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg_wdata[lfpd_pkg::GAIN_W-1:0];
                    lfpd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_wdata[lfpd_pkg::SAMPLE_W-1:0];
                    lfpd_pkg::CFG_D_ENABLE:  r_d_enable  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // error stage commits position, error and tick
            if (r_state == S_ERR) begin
                r_held      <= r_pos;
                r_prev_err  <= err;
                r_prev_tick <= r_in.tick_now;
            end

            // output register: a new load wins over the departing beat
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if ((r_state == S_CLASS) && !pos_info.use_div) begin
            r_pos <= pos_info.direct_pos;
        end
        if ((r_state == S_POS) && div_done) begin
            r_pos <= div_quo[POS_W-1:0];
        end
        if (r_state == S_ERR) begin
            r_err_neg  <= err_ext[POS_W];
            r_derr_neg <= derr[POS_W];
            r_ticks    <= (tick_delta == '0) ? lfpd_pkg::TICK_W'(1) : tick_delta;
        end
        if ((r_state == S_MUL) && mul_done) begin
            r_prop_mag <= prod_p[lfpd_pkg::PROD_W-1:lfpd_pkg::P_SHIFT];
        end
        if (r_state == S_SAT) begin
            if (diff_full > SAT_HI) begin
                r_diff <= SAT_HI[DIFF_W-1:0];
            end else if (diff_full < SAT_LO) begin
                r_diff <= SAT_LO[DIFF_W-1:0];
            end else begin
                r_diff <= diff_full[DIFF_W-1:0];
            end
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/lfpd_position.sv
// ============================================================================
// lfpd_position: sensor classification
// Threshold compares, inner weighted and plain sums, and the position source.
// ============================================================================
module lfpd_position (
    input  lfpd_pkg::t_in_beat                  i_beat,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]       i_threshold,
    input  logic [lfpd_pkg::POS_W-1:0]          i_held,
    output lfpd_pkg::t_pos_info                 o_info
);

    logic mid;
    logic lft;
    logic rgt;
    logic [lfpd_pkg::WSUM_W-1:0] s1;
    logic [lfpd_pkg::WSUM_W-1:0] s2;
    logic [lfpd_pkg::WSUM_W-1:0] s3;

    always_comb begin
        // over-the-line flags
        mid = (i_beat.sample_inner_1 >= i_threshold) ||
              (i_beat.sample_inner_2 >= i_threshold) ||
              (i_beat.sample_inner_3 >= i_threshold);
        lft = i_beat.sample_left  >= i_threshold;
        rgt = i_beat.sample_right >= i_threshold;

        // weighted and plain sums of the inner sensors
        s1 = lfpd_pkg::WSUM_W'(i_beat.sample_inner_1);
        s2 = lfpd_pkg::WSUM_W'(i_beat.sample_inner_2);
        s3 = lfpd_pkg::WSUM_W'(i_beat.sample_inner_3);
        o_info.wsum = s1 + (s2 << 1) + (s3 << 1) + s3;
        o_info.nsum = lfpd_pkg::NSUM_W'(s1 + s2 + s3);

        // inner sensors with a zero sum keep the held position
        o_info.use_div = mid && (o_info.nsum != '0);
        if (!mid && (lft != rgt)) begin
            o_info.direct_pos = lft ? '0 : lfpd_pkg::POS_RIGHT_EDGE;
        end else begin
            o_info.direct_pos = i_held;
        end
    end

endmodule

// File: hdl/lfpd_serial_mul.sv
// ============================================================================
// lfpd_serial_mul: two-lane shift-add multiplier
// Gain bits are consumed LSB first, one per cycle, in both lanes at once.
// ============================================================================
module lfpd_serial_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfpd_pkg::t_mul_cmd            i_cmd,
    output logic                          o_done,
    output logic [lfpd_pkg::PROD_W-1:0]   o_prod_p,
    output logic [lfpd_pkg::PROD_W-1:0]   o_prod_d
);

    localparam int ACC_W = lfpd_pkg::PROD_W + 1;

    logic                              r_busy;
    logic                              r_done;
    logic [lfpd_pkg::MUL_CNT_W-1:0]    r_cnt;
    logic [ACC_W-1:0]                  r_acc_p;
    logic [ACC_W-1:0]                  r_acc_d;
    logic [lfpd_pkg::MAG_W-1:0]        r_mag_p;
    logic [lfpd_pkg::MAG_W-1:0]        r_mag_d;
    logic [ACC_W-1:0]                  n_acc_p;
    logic [ACC_W-1:0]                  n_acc_d;

    // one add-and-shift step: upper half gains the multiplicand when bit 0 is set
    function automatic logic [ACC_W-1:0] mul_step(input logic [ACC_W-1:0] acc,
                                                  input logic [lfpd_pkg::MAG_W-1:0] mag);
        logic [lfpd_pkg::MAG_W:0] hi;
        hi = acc[ACC_W-1:lfpd_pkg::GAIN_W] + (acc[0] ? {1'b0, mag} : '0);
        return {1'b0, hi, acc[lfpd_pkg::GAIN_W-1:1]};
    endfunction

    always_comb begin
        n_acc_p = mul_step(r_acc_p, r_mag_p);
        n_acc_d = mul_step(r_acc_d, r_mag_d);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= lfpd_pkg::MUL_CNT_W'(lfpd_pkg::GAIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lfpd_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc_p <= ACC_W'(i_cmd.gain_p);
            r_acc_d <= ACC_W'(i_cmd.gain_d);
            r_mag_p <= i_cmd.mag_p;
            r_mag_d <= i_cmd.mag_d;
        end else if (r_busy) begin
            r_acc_p <= n_acc_p;
            r_acc_d <= n_acc_d;
        end
    end

    assign o_done   = r_done;
    assign o_prod_p = r_acc_p[lfpd_pkg::PROD_W-1:0];
    assign o_prod_d = r_acc_d[lfpd_pkg::PROD_W-1:0];

endmodule

// File: hdl/lfpd_serial_div.sv
// ============================================================================
// lfpd_serial_div: restoring divider, one quotient bit per cycle
// Shared by the position average and the derivative term.
// ============================================================================
module lfpd_serial_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfpd_pkg::t_div_cmd            i_cmd,
    output logic                          o_done,
    output logic [lfpd_pkg::DIV_W-1:0]    o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [lfpd_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [lfpd_pkg::DVS_W-1:0]        r_rem;
    logic [lfpd_pkg::DIV_W-1:0]        r_quo;
    logic [lfpd_pkg::DVS_W-1:0]        r_dvs;
    logic [lfpd_pkg::DVS_W:0]          trial;
    logic [lfpd_pkg::DVS_W:0]          trial_sub;
    logic                              fits;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        trial     = {r_rem, r_quo[lfpd_pkg::DIV_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        fits      = trial >= {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lfpd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.rem_init;
            r_quo <= i_cmd.quo_init;
            r_dvs <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[lfpd_pkg::DVS_W-1:0] : trial[lfpd_pkg::DVS_W-1:0];
            r_quo <= {r_quo[lfpd_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
